/* sv/tct_pkg.sv */
// Package with the types, constants and state codes of the TCP connection tracker.
`timescale 1ns / 1ps
`default_nettype none
package tct_pkg;

  localparam int MaxEntries = 64;
  localparam int IdxW = $clog2(MaxEntries);
  localparam int CntW = $clog2(MaxEntries + 1);
  localparam int CountOutW = 7;

  localparam logic VERDICT_DROP = 1'b0;
  localparam logic VERDICT_ACCEPT = 1'b1;

  localparam logic [1:0] FN_ENFORCE = 2'd0;
  localparam logic [1:0] FN_ADD = 2'd1;
  localparam logic [1:0] FN_LOOKUP = 2'd2;
  localparam logic [1:0] FN_UPDATE = 2'd3;

  localparam logic [3:0] ST_CLOSED = 4'd0;
  localparam logic [3:0] ST_SYN_SENT = 4'd1;
  localparam logic [3:0] ST_SYN_RCVD = 4'd2;
  localparam logic [3:0] ST_EST = 4'd3;
  localparam logic [3:0] ST_FW1 = 4'd4;
  localparam logic [3:0] ST_FW2 = 4'd5;
  localparam logic [3:0] ST_CLOSING = 4'd6;
  localparam logic [3:0] ST_CLOSE_WAIT = 4'd7;
  localparam logic [3:0] ST_LAST_ACK = 4'd8;

  typedef struct packed {
    logic [1:0] func;
    logic [31:0] src_ip;
    logic [15:0] src_l4_port;
    logic [31:0] dst_ip;
    logic [15:0] dst_l4_port;
    logic syn_flag;
    logic ack_flag;
    logic fin_flag;
    logic rst_flag;
    logic [3:0] initial_state;
    logic [15:0] new_proxy_port;
  } in_t;

  typedef struct packed {
    logic verdict_accept;
    logic proxy_found;
    logic [15:0] found_proxy_port;
    logic table_full;
    logic [CountOutW-1:0] entry_count_out;
  } out_t;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [15:0] src_tcp_port;
    logic [31:0] dst_addr;
    logic [15:0] dst_tcp_port;
    logic [3:0] tcp_state;
    logic [15:0] proxy;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic rev;
    logic remove;
    logic accept;
    logic [3:0] next_state;
  } rule_t;

endpackage
`default_nettype wire

/* sv/tct_if.sv */
// Request and result channel interfaces of the TCP connection tracker.
`timescale 1ns / 1ps
`default_nettype none
interface tct_in_if;
  import tct_pkg::*;
  logic valid;
  logic ready;
  in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tct_out_if;
  import tct_pkg::*;
  logic valid;
  logic ready;
  out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/tct_cell.sv */
// One table cell holding a single connection entry in the shifting chain.
`timescale 1ns / 1ps
`default_nettype none
module tct_cell
  import tct_pkg::*;
(
  input wire logic clk_i,
  input wire cell_ctrl_t ctrl_i,
  input wire entry_t load_i,
  input wire entry_t next_i,
  output entry_t entry_o
);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= load_i;
    end else if (ctrl_i.shift) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

/* sv/tct_rule.sv */
// Match test and per-state TCP rules applied to the entry at the head of the chain.
`timescale 1ns / 1ps
`default_nettype none
module tct_rule
  import tct_pkg::*;
(
  input wire entry_t entry_i,
  input wire in_t req_i,
  output rule_t rule_o
);

  logic fwd, rev, syn, ack, fin, rst, enf;

  always_comb begin
    enf = (req_i.func == FN_ENFORCE);
    syn = req_i.syn_flag && enf;
    ack = req_i.ack_flag && enf;
    fin = req_i.fin_flag && enf;
    rst = req_i.rst_flag && enf;
    fwd = (req_i.src_ip == entry_i.src_addr) && (req_i.src_l4_port == entry_i.src_tcp_port) &&
          (req_i.dst_ip == entry_i.dst_addr) && (req_i.dst_l4_port == entry_i.dst_tcp_port) &&
          (rst || fin || ((entry_i.tcp_state == ST_CLOSED) && syn));
    rev = !fwd && (req_i.dst_ip == entry_i.src_addr) &&
          (req_i.dst_l4_port == entry_i.src_tcp_port) &&
          (req_i.src_ip == entry_i.dst_addr) && (req_i.src_l4_port == entry_i.dst_tcp_port);
    rule_o.rev = rev;
    rule_o.remove = 1'b0;
    rule_o.accept = VERDICT_DROP;
    rule_o.next_state = entry_i.tcp_state;
    if (fwd || rev) begin
      if (rst) begin
        rule_o.remove = 1'b1;
        rule_o.accept = VERDICT_ACCEPT;
      end else begin
        case (entry_i.tcp_state)
          ST_CLOSED: begin
            if (syn && !ack && !fin) begin
              rule_o.next_state = rev ? ST_SYN_RCVD : ST_SYN_SENT;
              rule_o.accept = VERDICT_ACCEPT;
            end
          end
          ST_SYN_SENT: begin
            if (syn && ack && !fin) begin
              rule_o.next_state = ST_EST;
              rule_o.accept = VERDICT_ACCEPT;
            end
          end
          ST_SYN_RCVD: begin
            if (ack && !syn && !fin) begin
              rule_o.next_state = ST_EST;
              rule_o.accept = VERDICT_ACCEPT;
            end else if (fin && fwd) begin
              rule_o.next_state = ST_FW1;
            end
          end
          ST_EST: begin
            if (!syn) begin
              if (fin) rule_o.next_state = rev ? ST_CLOSE_WAIT : ST_FW1;
              rule_o.accept = VERDICT_ACCEPT;
            end
          end
          ST_FW1: begin
            if (!syn) begin
              if (ack && fin && rev) rule_o.remove = 1'b1;
              else if (fin && fwd) rule_o.next_state = ST_FW1;
              else if (ack && rev) rule_o.next_state = ST_FW2;
              else if (fin && rev) rule_o.next_state = ST_CLOSING;
              rule_o.accept = VERDICT_ACCEPT;
            end
          end
          ST_FW2: begin
            if (!(syn || (!ack && fwd))) begin
              if (fin && rev) rule_o.remove = 1'b1;
              rule_o.accept = VERDICT_ACCEPT;
            end
          end
          ST_CLOSING: begin
            if (!syn && ack && !fin) begin
              rule_o.remove = rev;
              rule_o.accept = VERDICT_ACCEPT;
            end
          end
          ST_CLOSE_WAIT: begin
            if (!syn) begin
              if (rev) begin
                rule_o.accept = ack;
              end else begin
                if (fin) rule_o.next_state = ST_LAST_ACK;
                rule_o.accept = ack || fin;
              end
            end
          end
          ST_LAST_ACK: begin
            if (!syn && ack && rev) begin
              rule_o.remove = 1'b1;
              rule_o.accept = VERDICT_ACCEPT;
            end
          end
          default: begin
            rule_o.accept = VERDICT_DROP;
          end
        endcase
      end
    end
  end

endmodule
`default_nettype wire

/* sv/tcp_connection_tracker_top.sv */
// Top level of the TCP connection tracker: control, cell chain and result register.
`timescale 1ns / 1ps
`default_nettype none
// The entries sit in a chain of cells that shifts towards cell zero, where one rule unit
// examines the head entry each cycle and writes it back to the tail of the valid part
// unless it is removed, so order is kept and removal compacts the table. An enforce,
// lookup or update request scans every entry present when it was taken, then finishes; an
// add loads its entry at the tail or flags the table full. One request is handled at a
// time; a finished result waits in an output register.
module tcp_connection_tracker_top
  import tct_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  tct_in_if.sink in_i,
  tct_out_if.source out_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN = 3'b100
  } state_e;

  state_e state_q, state_d;
  in_t req_q;
  logic [CntW-1:0] cnt_q, cnt_d, steps_q, steps_d;
  logic verdict_q, verdict_d, found_q, found_d, full_q, full_d;
  logic [15:0] fport_q, fport_d;
  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  entry_t cell_entry [MaxEntries];
  cell_ctrl_t cell_ctrl [MaxEntries];
  entry_t load_data;
  logic shift_en, load_en;
  logic [IdxW-1:0] load_idx;
  rule_t rule;
  entry_t head;

  assign head = cell_entry[0];

  tct_rule u_rule (
    .entry_i(head),
    .req_i(req_q),
    .rule_o(rule)
  );

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    entry_t next;
    if (g == MaxEntries - 1) begin : g_last
      assign next = load_data;
    end else begin : g_mid
      assign next = cell_entry[g+1];
    end
    assign cell_ctrl[g].shift = shift_en;
    assign cell_ctrl[g].load = load_en && (load_idx == IdxW'(g));
    tct_cell u_cell (
      .clk_i(clk_i),
      .ctrl_i(cell_ctrl[g]),
      .load_i(load_data),
      .next_i(next),
      .entry_o(cell_entry[g])
    );
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data = out_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    steps_d = steps_q;
    verdict_d = verdict_q;
    found_d = found_q;
    full_d = full_q;
    fport_d = fport_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_d = out_q;
    shift_en = 1'b0;
    load_en = 1'b0;
    load_idx = IdxW'(cnt_q - CntW'(1));
    load_data = head;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          state_d = S_SCAN;
          steps_d = cnt_q;
          verdict_d = VERDICT_DROP;
          found_d = 1'b0;
          full_d = 1'b0;
          fport_d = 16'd0;
        end
      end
      S_SCAN: begin
        if (req_q.func == FN_ADD) begin
          state_d = S_FIN;
          if (cnt_q == CntW'(MaxEntries)) begin
            full_d = 1'b1;
          end else begin
            load_en = 1'b1;
            load_idx = IdxW'(cnt_q);
            load_data.src_addr = req_q.src_ip;
            load_data.src_tcp_port = req_q.src_l4_port;
            load_data.dst_addr = req_q.dst_ip;
            load_data.dst_tcp_port = req_q.dst_l4_port;
            load_data.tcp_state = req_q.initial_state;
            load_data.proxy = 16'd0;
            cnt_d = cnt_q + CntW'(1);
          end
        end else if (steps_q == '0) begin
          state_d = S_FIN;
        end else begin
          shift_en = 1'b1;
          steps_d = steps_q - CntW'(1);
          if (req_q.func == FN_ENFORCE) begin
            load_data.tcp_state = rule.next_state;
            load_en = !rule.remove;
            verdict_d = verdict_q | rule.accept;
            if (rule.remove) cnt_d = cnt_q - CntW'(1);
          end else begin
            load_en = 1'b1;
            if (rule.rev && !found_q) begin
              found_d = 1'b1;
              if (req_q.func == FN_UPDATE) load_data.proxy = req_q.new_proxy_port;
              else fport_d = head.proxy;
            end
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = S_IDLE;
          out_valid_d = 1'b1;
          out_d.verdict_accept = (req_q.func == FN_ENFORCE) && verdict_q;
          out_d.proxy_found = (req_q.func == FN_LOOKUP) && found_q;
          out_d.found_proxy_port = (req_q.func == FN_LOOKUP) ? fport_q : 16'd0;
          out_d.table_full = full_q;
          out_d.entry_count_out = CountOutW'(cnt_q);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      steps_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      steps_q <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) req_q <= in_i.data;
    verdict_q <= verdict_d;
    found_q <= found_d;
    full_q <= full_d;
    fport_q <= fport_d;
    out_q <= out_d;
  end

endmodule
`default_nettype wire
